>>> src/rcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and the byte update function of the CRC engine.
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int CRC_W     = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY       = 1'b1;

    localparam logic             MODE_RESET = 1'b1;
    localparam logic [CRC_W-1:0] POLY_RESET = 64'hC96C5795D7870F42;
    localparam logic [CRC_W-1:0] ONES64     = 64'hFFFFFFFFFFFFFFFF;
    localparam logic [CRC_W-1:0] ONES32     = 64'h00000000FFFFFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0]       byte_in,
                                                   input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] c;
        c = crc ^ {56'd0, byte_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/rcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_front
// Input side: accepts bytes with their last flag into a short queue.
// ----------------------------------------------------------------------------
module rcc_front import rcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + QCW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

>>> src/rcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_back
// CRC datapath: config registers, running CRC and the result register.
// ----------------------------------------------------------------------------
module rcc_back import rcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CRC_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    input  t_item                i_item,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [CRC_W-1:0]     o_crc_value
);

    logic             r_mode;
    logic [CRC_W-1:0] r_poly;
    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] r_res;
    logic             r_res_valid;
    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] n_crc;
    logic             take;

    assign mask    = r_mode ? ONES64 : ONES32;
    assign n_crc   = crc_byte(r_crc & mask, i_item.data, r_poly & mask) & mask;
    assign o_ready = !i_item.last || !r_res_valid || i_pop;
    assign take    = i_valid && o_ready;

    assign o_empty     = !r_res_valid;
    assign o_crc_value = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_poly      <= POLY_RESET;
            r_crc       <= ONES64;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_WIDTH_MODE) begin
                r_mode <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_POLY) begin
                r_poly <= i_cfg_data;
            end
            if (take) begin
                r_crc <= i_item.last ? ONES64 : n_crc;
            end
            if (take && i_item.last) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_item.last) begin
            r_res <= (n_crc ^ mask) & mask;
        end
    end

endmodule

>>> src/reflected_crc32_crc64_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflected_crc32_crc64_byte_engine
// Byte-wise reflected CRC-32 / CRC-64 engine with programmable polynomial.
//
// Input queue: drive i_data_byte and i_last_byte with i_push; an item is
// taken on a clock edge where i_push is high and o_full is low. Bytes go
// into a four-entry queue; the back end absorbs one byte per cycle, so the
// sustained rate is one byte per cycle while no last byte waits on a held
// result, set by the combinational eight-step byte update of the running CRC.
// Result queue: when the byte marked last has been absorbed, the final CRC
// sits on o_crc_value while o_empty is low; i_pop takes it. If the result is
// not popped, non-last bytes still flow; the next last byte waits in the
// queue, and once the queue fills o_full rises.
// Config: i_cfg_we writes register i_cfg_idx (0: width mode, 1: reflected
// polynomial) from i_cfg_data; users must write only while the block is
// idle; the block does not enforce this.
// Reset (i_rst_n low, synchronous) empties both queues, selects 64-bit
// mode with the CRC-64/XZ polynomial and loads the running CRC with ones.
// ----------------------------------------------------------------------------
module reflected_crc32_crc64_byte_engine import rcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CRC_W-1:0]     i_cfg_data,
    input  logic                 i_push,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [CRC_W-1:0]     o_crc_value
);

    t_item in_item;
    t_item q_item;
    logic  q_valid;
    logic  q_ready;

    assign in_item.data = i_data_byte;
    assign in_item.last = i_last_byte;

    rcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (in_item),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    rcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_ready     (q_ready),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_crc_value (o_crc_value)
    );

endmodule

>>> src/rcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks on the CRC engine, bound to the top level.
// ----------------------------------------------------------------------------
module rcc_checker import rcc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CRC_W-1:0]     i_cfg_data,
    input logic                 i_push,
    input logic                 o_full,
    input logic                 i_pop,
    input logic                 o_empty,
    input logic [CRC_W-1:0]     o_crc_value
);

    logic r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we && i_cfg_idx == CFG_WIDTH_MODE) begin
            r_mode <= i_cfg_data[0];
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_crc_value)))
        else $error("waiting result lost or changed");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> $past(i_push))
        else $error("input queue filled without a push");

    a_mode32_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !r_mode) |-> (o_crc_value[63:32] == 32'd0))
        else $error("upper CRC bits set in 32-bit mode");

endmodule

bind reflected_crc32_crc64_byte_engine rcc_checker u_rcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_push      (i_push),
    .o_full      (o_full),
    .i_pop       (i_pop),
    .o_empty     (o_empty),
    .o_crc_value (o_crc_value)
);

>>> sim/reflected_crc32_crc64_byte_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflected_crc32_crc64_byte_engine_tb
// Self-checking bench for the byte-wise reflected CRC-32/CRC-64 engine.
//
// A directed table runs first. It covers the standard check strings in both
// widths, byte extremes, a width switch in the middle of a message, and a zero
// and an all-ones polynomial. Random messages follow, in phases. Each phase
// writes a new width and polynomial while the engine is idle. Both sides
// insert random gaps. One phase holds off the result side for a long stretch
// so that the input queue backs up. A CRC with a typed value is checked
// against it, others against a bit-serial model of the bench's running CRC.
// ----------------------------------------------------------------------------
module reflected_crc32_crc64_byte_engine_tb;
    import rcc_pkg::*;

    localparam int          RAND_ITEMS     = 600;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] MASK32         = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    // value: write data for a config row, typed CRC for a byte row with typed set
    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [63:0]          value;
        logic [7:0]           data;
        logic                 last;
        logic                 typed;
    } t_dir_row;

    localparam int DIR_ROWS = 31;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // CRC-64/XZ of "123456789" straight after reset
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h31, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h32, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h33, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h34, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h35, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h36, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h37, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h38, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h995D_C9BB_DF19_39FA, 8'h39, 1'b1, 1'b1},
        // CRC-32; junk in the upper polynomial half must be ignored
        '{ROW_CFG,  CFG_WIDTH_MODE, 64'h0, 8'h00, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_POLY,       64'hFFFF_FFFF_EDB8_8320, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h31, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h32, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h33, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h34, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h35, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h36, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h37, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h38, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0000_0000_CBF4_3926, 8'h39, 1'b1, 1'b1},
        // single-byte messages at the byte extremes
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h00, 1'b1, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'hFF, 1'b1, 1'b0},
        // switch 32 -> 64 mid-message, upper register half starts at zero
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'hA5, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_WIDTH_MODE, 64'h1, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h5A, 1'b1, 1'b0},
        // zero polynomial: plain shift of all ones
        '{ROW_CFG,  CFG_POLY,       64'h0, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'hFF00_0000_0000_0000, 8'hFF, 1'b1, 1'b1},
        // all-ones polynomial
        '{ROW_CFG,  CFG_POLY,       64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE, CFG_WIDTH_MODE, 64'h0, 8'hFF, 1'b1, 1'b0},
        '{ROW_CFG,  CFG_POLY,       64'hC96C_5795_D787_0F42, 8'h00, 1'b0, 1'b0}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CRC_W-1:0]     i_cfg_data  = '0;
    logic                 i_push      = 1'b0;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_last_byte = 1'b0;
    logic                 i_pop       = 1'b0;
    logic                 o_full;
    logic                 o_empty;
    logic [CRC_W-1:0]     o_crc_value;

    // model of the engine
    logic        mode_64   = 1'b1;
    logic [63:0] poly_sel  = 64'hC96C_5795_D787_0F42;
    logic [63:0] crc_run   = '1;
    logic [63:0] pending_crcs [$];

    logic send_idle = 1'b0;
    logic recv_idle = 1'b0;
    logic hold_req  = 1'b0;

    int err_count    = 0;
    int bytes_in     = 0;
    int msgs_in      = 0;
    int crcs_checked = 0;
    int cfg_writes   = 0;
    int rand_items   = 0;
    int full_cycles  = 0;
    int quiet_cycles = 0;

    reflected_crc32_crc64_byte_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_crc_value (o_crc_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] shift_in_byte(input logic [63:0] crc,
                                                  input logic [7:0]  b,
                                                  input logic [63:0] poly);
        logic [63:0] c;
        c = crc ^ {56'd0, b};
        repeat (8) c = (c >> 1) ^ (poly & {64{c[0]}});
        return c;
    endfunction

    function automatic void note_error(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR %s: expected %h, got %h", what, want, got);
        end
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic l, input logic typed,
                               input logic [63:0] want);
        logic [63:0] mask;
        logic [63:0] c;
        mask = mode_64 ? '1 : MASK32;
        c = shift_in_byte(crc_run & mask, b, poly_sel & mask) & mask;
        bytes_in++;
        if (l) begin
            pending_crcs.push_back(typed ? want : (c ^ mask));
            crc_run = '1;
            msgs_in++;
        end else begin
            crc_run = c;
        end
    endtask

    // entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
                             input logic [63:0] want);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_push      = 1'b0;
            i_data_byte = 8'($urandom);
            i_last_byte = 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_push      = 1'b1;
        i_data_byte = b;
        i_last_byte = l;
        do @(posedge i_clk); while (o_full);
        absorb_byte(b, l, typed, want);
        @(negedge i_clk);
    endtask

    // bytes without a result may still sit in the input queue: let them drain
    task automatic wait_idle();
        i_push = 1'b0;
        while (pending_crcs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        if (idx == CFG_WIDTH_MODE) begin
            mode_64 = val[0];
        end else begin
            poly_sel = val;
        end
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [63:0] pick_poly();
        case ($urandom_range(0, 6))
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'hC96C_5795_D787_0F42;
            3:       return 64'h0000_0000_EDB8_8320;
            4:       return 64'h0000_0000_82F6_3B78;
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    initial begin : stimulus
        int                   phase;
        int                   phase_len;
        int                   msg_left;
        logic                 first_idx;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           b;
        phase    = 0;
        msg_left = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[r].idx, dir_rows[r].value);
            end else begin
                push_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed,
                          dir_rows[r].value);
            end
        end

        // phase boundaries may cut a message: the new setting applies mid-message
        while (rand_items < RAND_ITEMS) begin
            wait_idle();
            first_idx = 1'($urandom);
            for (int k = 0; k < 2; k++) begin
                idx = first_idx ^ CFG_IDX_W'(k);
                if (idx == CFG_WIDTH_MODE) begin
                    write_reg(idx, {32'($urandom), 32'($urandom)});
                end else begin
                    write_reg(idx, pick_poly());
                end
            end
            if (phase == 2) begin
                send_idle = 1'b0;
                hold_req  = 1'b1;
                phase_len = 200;
            end else begin
                send_idle = 1'($urandom);
                phase_len = $urandom_range(40, 120);
            end
            repeat (phase_len) begin
                if (msg_left == 0) begin
                    msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                           : $urandom_range(1, 8);
                end
                b = 8'($urandom);
                push_byte(b, msg_left == 1, 1'b0, 64'h0);
                msg_left--;
                rand_items++;
            end
            phase++;
        end

        i_push = 1'b0;
        while (pending_crcs.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("covered %0d bytes in %0d messages over %0d config writes",
                 bytes_in, msgs_in, cfg_writes);
        $display("checked %0d CRCs, input held off %0d cycles, %0d errors",
                 crcs_checked, full_cycles, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : result_side
        int          gap;
        logic [63:0] want;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = recv_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                i_pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop = 1'b1;
            do @(posedge i_clk); while (o_empty);
            if (pending_crcs.size() == 0) begin
                note_error("CRC with none pending", 64'h0, o_crc_value);
            end else begin
                want = pending_crcs.pop_front();
                if (o_crc_value !== want) begin
                    note_error("crc_value", want, o_crc_value);
                end
            end
            crcs_checked++;
            if (crcs_checked % 16 == 0) begin
                recv_idle = 1'($urandom);
            end
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_push && o_full) begin
            full_cycles <= full_cycles + 1;
        end
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d CRCs pending",
                     quiet_cycles, pending_crcs.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule
